// ----- hw/rtl/czw_pkg.sv -----
// Package for the cluster zone warning block.
// Holds coordinate widths, register indexes, reset bounds and zone codes.
// No dependencies.
package czw_pkg;

    localparam int COORD_BITS     = 16;
    localparam int DIST_BITS      = 2 * COORD_BITS;
    localparam int NUM_CFG        = 8;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int IN_DATA_BITS   = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [DIST_BITS-1:0]         t_dist;
    typedef logic [1:0]                   t_code;

    // Zone codes; a lower code is more severe.
    localparam t_code CODE_RED    = 2'd0;
    localparam t_code CODE_YELLOW = 2'd1;
    localparam t_code CODE_NONE   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RED_X_LOW     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RED_X_HIGH    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RED_Y_LOW     = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RED_Y_HIGH    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_YELLOW_X_LOW  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_YELLOW_X_HIGH = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_YELLOW_Y_LOW  = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_YELLOW_Y_HIGH = 3'd7;

    localparam t_coord CFG_RESET [NUM_CFG] = '{
        COORD_BITS'(-307), COORD_BITS'(307), COORD_BITS'(0),   COORD_BITS'(512),
        COORD_BITS'(-307), COORD_BITS'(307), COORD_BITS'(538), COORD_BITS'(1024)
    };

endpackage

// ----- hw/rtl/cluster_zone_warning_top.sv -----
// Top level of the cluster zone warning block.
// Depends on czw_pkg for widths, register indexes and zone codes.
//
// Usage:
// Points stream in on the s_axis side, one beat per point or marker. tdata carries
// x and y, tuser says whether the beat has a point and whether it closes a
// cluster, and tlast closes the cluster and the frame together. Each closing
// beat yields one result beat on the m_axis side: the cluster's code, whether
// the cluster held a point, the worst code of the frame so far and, on tlast,
// the end of the frame. Other beats yield nothing.
// An input beat passes an input register, a stage with the two squares and the
// zone tests, and the result register on its way to the result beat.
// Throughput is one beat per cycle while the receiver does not stall; the
// nearest-point compare (one add and one 32-bit compare) is the loop that sets it.
// Reset restores the default zone bounds, empties the pipeline and clears the
// cluster and frame state. When the receiver stalls, the result register
// holds and beats that close nothing keep flowing; once a closing beat waits
// in the second stage and the input register is full, tready drops. Zone bounds
// are to be written on the cfg port while the block is idle; it is not enforced.
module cluster_zone_warning_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [czw_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [czw_pkg::COORD_BITS-1:0]    i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // point_x, point_y
    input  logic [czw_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // has_point, cluster_end
    input  logic [1:0]                        i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // cluster_code, frame_code, zero padding
    output logic [czw_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // cluster_valid
    output logic                              o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);
    import czw_pkg::*;

    function automatic logic in_zone(t_coord xl, t_coord xh, t_coord yl, t_coord yh,
                                     t_coord x, t_coord y);
        in_zone = (xl < x) && (x <= xh) && (yl <= y) && (y < yh);
    endfunction

    t_coord r_cfg [NUM_CFG];

    // Input stage.
    logic   r_s1_valid;
    t_coord r_s1_x, r_s1_y;
    logic   r_s1_has, r_s1_cl, r_s1_fr;

    // Squares and zone stage.
    logic   r_s2_valid;
    t_dist  r_s2_xsq, r_s2_ysq;
    t_coord r_s2_x, r_s2_y;
    logic   r_s2_red, r_s2_yel;
    logic   r_s2_has, r_s2_cl, r_s2_fr;

    // Cluster and frame state.
    t_dist  r_near_dist;
    t_coord r_near_x, r_near_y;
    logic   r_seen;
    t_code  r_frame_worst;

    // Result register.
    logic  r_o_valid;
    t_code r_o_cl_code, r_o_fr_code;
    logic  r_o_cl_valid, r_o_done;

    logic out_free, s2_close, s2_go, s2_free, s1_free;
    logic signed [DIST_BITS-1:0] x_sq, y_sq;
    t_dist  d;
    t_code  p_code;
    logic   near_red, near_yel;
    t_code  near_code;
    logic   take;
    logic   n_seen;
    t_code  n_code, n_frame;
    t_dist  n_dist;
    t_coord n_near_x, n_near_y;

    assign out_free = !r_o_valid || i_m_axis_tready;
    assign s2_close = r_s2_cl || r_s2_fr;
    assign s2_go    = r_s2_valid && (!s2_close || out_free);
    assign s2_free  = !r_s2_valid || s2_go;
    assign s1_free  = !r_s1_valid || s2_free;

    assign o_s_axis_tready = s1_free;

    // Products are taken at full width, so the sign extends before the multiply.
    assign x_sq = r_s1_x * r_s1_x;
    assign y_sq = r_s1_y * r_s1_y;

    // The kept point is tested against the bounds in force when its cluster
    // closes; this runs beside the distance compare, not after it.
    assign near_red  = in_zone(r_cfg[CFG_RED_X_LOW], r_cfg[CFG_RED_X_HIGH],
                               r_cfg[CFG_RED_Y_LOW], r_cfg[CFG_RED_Y_HIGH],
                               r_near_x, r_near_y);
    assign near_yel  = in_zone(r_cfg[CFG_YELLOW_X_LOW], r_cfg[CFG_YELLOW_X_HIGH],
                               r_cfg[CFG_YELLOW_Y_LOW], r_cfg[CFG_YELLOW_Y_HIGH],
                               r_near_x, r_near_y);
    assign near_code = near_red ? CODE_RED : (near_yel ? CODE_YELLOW : CODE_NONE);

    // Two squares of COORD_BITS signed values never carry out of DIST_BITS.
    assign d        = r_s2_xsq + r_s2_ysq;
    assign p_code   = r_s2_red ? CODE_RED : (r_s2_yel ? CODE_YELLOW : CODE_NONE);
    assign take     = r_s2_has && (!r_seen || d < r_near_dist);
    assign n_seen   = r_seen || r_s2_has;
    assign n_code   = take ? p_code : near_code;
    assign n_dist   = take ? d : r_near_dist;
    assign n_near_x = take ? r_s2_x : r_near_x;
    assign n_near_y = take ? r_s2_y : r_near_y;
    assign n_frame  = (n_seen && n_code < r_frame_worst) ? n_code : r_frame_worst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
        if (s1_free && i_s_axis_tvalid) begin
            r_s1_x   <= i_s_axis_tdata[COORD_BITS-1:0];
            r_s1_y   <= i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            r_s1_has <= i_s_axis_tuser[0];
            r_s1_cl  <= i_s_axis_tuser[1];
            r_s1_fr  <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_xsq <= $unsigned(x_sq);
            r_s2_ysq <= $unsigned(y_sq);
            r_s2_x   <= r_s1_x;
            r_s2_y   <= r_s1_y;
            r_s2_red <= in_zone(r_cfg[CFG_RED_X_LOW], r_cfg[CFG_RED_X_HIGH],
                                r_cfg[CFG_RED_Y_LOW], r_cfg[CFG_RED_Y_HIGH],
                                r_s1_x, r_s1_y);
            r_s2_yel <= in_zone(r_cfg[CFG_YELLOW_X_LOW], r_cfg[CFG_YELLOW_X_HIGH],
                                r_cfg[CFG_YELLOW_Y_LOW], r_cfg[CFG_YELLOW_Y_HIGH],
                                r_s1_x, r_s1_y);
            r_s2_has <= r_s1_has;
            r_s2_cl  <= r_s1_cl;
            r_s2_fr  <= r_s1_fr;
        end
    end

    // The nearest point is kept as coordinates, so bounds written between
    // clusters' points apply when the cluster closes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_dist   <= '1;
            r_near_x      <= '0;
            r_near_y      <= '0;
            r_seen        <= 1'b0;
            r_frame_worst <= CODE_NONE;
        end else if (s2_go) begin
            if (s2_close) begin
                r_near_dist   <= '1;
                r_near_x      <= '0;
                r_near_y      <= '0;
                r_seen        <= 1'b0;
                r_frame_worst <= r_s2_fr ? CODE_NONE : n_frame;
            end else begin
                r_near_dist <= n_dist;
                r_near_x    <= n_near_x;
                r_near_y    <= n_near_y;
                r_seen      <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= s2_go && s2_close;
        end
        if (out_free && s2_go && s2_close) begin
            r_o_cl_code  <= n_seen ? n_code : CODE_NONE;
            r_o_cl_valid <= n_seen;
            r_o_fr_code  <= n_frame;
            r_o_done     <= r_s2_fr;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_BITS - 4)'(0), r_o_fr_code, r_o_cl_code};
    assign o_m_axis_tuser  = r_o_cl_valid;
    assign o_m_axis_tlast  = r_o_done;

    a_empty_cluster_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_cl_valid |-> r_o_cl_code == CODE_NONE)
        else $error("empty cluster reported with a zone code");

    a_frame_at_least_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_cl_valid |-> r_o_fr_code <= r_o_cl_code)
        else $error("frame code less severe than its cluster code");

    a_close_clears_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go && s2_close |=> !r_seen)
        else $error("cluster state not cleared after a closing beat");

    a_frame_end_clears_worst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go && r_s2_fr |=> r_frame_worst == CODE_NONE)
        else $error("frame state not cleared after frame end");

endmodule

// ----- tb/testbench.sv -----
// Testbench for cluster_zone_warning_top: drives point, marker and frame-end beats
// with random gaps and receiver stalls, and predicts each cluster and frame result.
// Depends on czw_pkg for coordinate types, register indexes and zone codes.
`timescale 1ns / 1ps

module testbench;
    import czw_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        t_code cluster_code;
        logic  cluster_valid;
        t_code frame_code;
        logic  frame_done;
    } t_zone_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [COORD_BITS-1:0]    i_cfg_wdata = '0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [IN_DATA_BITS-1:0]  i_s_axis_tdata = '0;
    logic [1:0]               i_s_axis_tuser = '0;
    logic                     i_s_axis_tlast = 1'b0;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic                     o_m_axis_tuser;
    logic                     o_m_axis_tlast;

    // Predictor state: zone bounds plus the running cluster and frame summary.
    t_coord zone_bounds [NUM_CFG];
    t_dist  near_dist;
    t_coord near_x;
    t_coord near_y;
    bit     near_seen;
    t_code  frame_worst;

    t_zone_result pending_zone_results [$];

    int errors       = 0;
    int beats_in     = 0;
    int results_seen = 0;
    int bound_sets   = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit tx_throttle  = 1'b1;
    bit rx_throttle  = 1'b1;

    cluster_zone_warning_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit in_zone(input int base, input t_coord x, input t_coord y);
        return zone_bounds[base] < x && x <= zone_bounds[base + 1] &&
               zone_bounds[base + 2] <= y && y < zone_bounds[base + 3];
    endfunction

    function automatic void clear_cluster();
        near_dist = '1;
        near_x    = '0;
        near_y    = '0;
        near_seen = 1'b0;
    endfunction

    task automatic predict_zone_result(input t_coord px, input t_coord py, input bit has_pt,
                                       input bit cl_end, input bit fr_end);
        t_dist        d;
        t_zone_result r;
        longint       sx;
        longint       sy;
        if (has_pt) begin
            sx = px;
            sy = py;
            d  = t_dist'(sx * sx + sy * sy);
            // Strict compare keeps the earlier point on a tie.
            if (!near_seen || d < near_dist) begin
                near_dist = d;
                near_x    = px;
                near_y    = py;
                near_seen = 1'b1;
            end
        end
        if (!cl_end && !fr_end)
            return;
        r.cluster_code = CODE_NONE;
        if (near_seen) begin
            if (in_zone(CFG_RED_X_LOW, near_x, near_y))
                r.cluster_code = CODE_RED;
            else if (in_zone(CFG_YELLOW_X_LOW, near_x, near_y))
                r.cluster_code = CODE_YELLOW;
            if (r.cluster_code < frame_worst)
                frame_worst = r.cluster_code;
        end
        r.cluster_valid = near_seen;
        r.frame_code    = frame_worst;
        r.frame_done    = fr_end;
        pending_zone_results = {pending_zone_results, r};
        clear_cluster();
        if (fr_end)
            frame_worst = CODE_NONE;
    endtask

    function automatic int pick_gap();
        int r;
        if (!tx_throttle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly points around the zones, some hugging a bound, some anywhere.
    function automatic t_coord pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return t_coord'(int'($urandom_range(0, 2800)) - 1400);
        if (r < 85)
            return t_coord'(zone_bounds[$urandom_range(0, NUM_CFG - 1)] +
                            int'($urandom_range(0, 4)) - 2);
        return t_coord'($urandom);
    endfunction

    task automatic send_beat(input t_coord px, input t_coord py, input bit has_pt,
                             input bit cl_end, input bit fr_end);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {py, px};
        i_s_axis_tuser  <= {cl_end, has_pt};
        i_s_axis_tlast  <= fr_end;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_zone_result(px, py, has_pt, cl_end, fr_end);
        beats_in++;
    endtask

    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_zone_results.size() != 0) @(posedge i_clk);
        // Trailing non-closing beats may still sit in the pipeline.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all eight bounds, red zone first, in register index order.
    task automatic load_zone_bounds(input t_coord bounds [NUM_CFG]);
        for (int i = 0; i < NUM_CFG; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= CFG_ADDR_BITS'(i);
            i_cfg_wdata <= bounds[i];
            @(posedge i_clk);
            zone_bounds[i] = bounds[i];
        end
        i_cfg_we <= 1'b0;
        bound_sets++;
    endtask

    function automatic void random_zone(inout t_coord bounds [NUM_CFG], input int base,
                                        input bit near_origin);
        int xl;
        int yl;
        if (near_origin) begin
            xl = int'($urandom_range(0, 1600)) - 800;
            yl = int'($urandom_range(0, 1600)) - 800;
            bounds[base]     = t_coord'(xl);
            bounds[base + 1] = t_coord'(xl + int'($urandom_range(0, 1200)) - 100);
            bounds[base + 2] = t_coord'(yl);
            bounds[base + 3] = t_coord'(yl + int'($urandom_range(0, 1200)) - 100);
        end else begin
            for (int i = 0; i < 4; i++)
                bounds[base + i] = t_coord'($urandom);
        end
    endfunction

    // Inclusive and exclusive edges of the default zones, one point per cluster.
    task automatic test_default_zone_edges();
        send_beat(307, 0, 1'b1, 1'b1, 1'b0);
        send_beat(-307, 100, 1'b1, 1'b1, 1'b0);
        send_beat(0, 511, 1'b1, 1'b1, 1'b0);
        send_beat(0, 512, 1'b1, 1'b1, 1'b0);
        send_beat(0, 538, 1'b1, 1'b1, 1'b0);
        send_beat(0, 1024, 1'b1, 1'b1, 1'b0);
        // Frame end without the cluster end flag still closes the cluster.
        send_beat(0, 1023, 1'b1, 1'b0, 1'b1);
    endtask

    task automatic test_nearest_point_rules();
        // Equal distances: the earlier point, inside red, must win.
        send_beat(300, 400, 1'b1, 1'b0, 1'b0);
        send_beat(400, 300, 1'b1, 1'b0, 1'b0);
        send_beat(16'sh7fff, 16'sh7fff, 1'b0, 1'b1, 1'b0);
        // Cluster closed with no point at all.
        send_beat(0, 0, 1'b0, 1'b1, 1'b0);
        // A point on the closing beat joins the cluster first.
        send_beat(1000, 1000, 1'b1, 1'b0, 1'b0);
        send_beat(0, 600, 1'b1, 1'b1, 1'b0);
        send_beat(-1, -1, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_coordinate_extremes();
        t_coord bounds [NUM_CFG];
        send_beat(-32768, -32768, 1'b1, 1'b0, 1'b0);
        send_beat(32767, 32767, 1'b1, 1'b0, 1'b0);
        send_beat(32767, -32768, 1'b1, 1'b0, 1'b0);
        send_beat(-32768, 32767, 1'b1, 1'b1, 1'b1);
        drain_pipeline();
        // Red covers the whole plane but its exclusive edges; yellow is inverted.
        bounds = '{-32768, 32767, -32768, 32767, 100, -100, 100, -100};
        load_zone_bounds(bounds);
        send_beat(-32767, -32768, 1'b1, 1'b1, 1'b0);
        send_beat(-32768, 5, 1'b1, 1'b1, 1'b0);
        send_beat(32767, 32766, 1'b1, 1'b1, 1'b0);
        send_beat(0, 32767, 1'b1, 1'b1, 1'b0);
        send_beat(0, 0, 1'b0, 1'b0, 1'b1);
        drain_pipeline();
    endtask

    task automatic test_random_traffic(input int n_items);
        int n_pts;
        int sent;
        bit on_marker;
        bit end_frame;
        bit tlast_only;
        bit closing;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 19) == 0)
                tx_throttle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0)
                rx_throttle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 85) begin
                n_pts      = $urandom_range(1, 6);
                on_marker  = ($urandom_range(0, 4) == 0);
                end_frame  = ($urandom_range(0, 3) == 0);
                tlast_only = ($urandom_range(0, 1) == 0);
                for (int k = 0; k < n_pts; k++) begin
                    closing = (k == n_pts - 1) && !on_marker;
                    send_beat(pick_coord(), pick_coord(), 1'b1,
                              closing && !(end_frame && tlast_only), closing && end_frame);
                end
                if (on_marker)
                    send_beat(t_coord'($urandom), t_coord'($urandom), 1'b0,
                              !(end_frame && tlast_only), end_frame);
                sent += n_pts + int'(on_marker);
            end else begin
                send_beat(t_coord'($urandom), t_coord'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom));
                sent++;
            end
        end
        drain_pipeline();
    endtask

    task automatic test_random_bound_sets();
        t_coord bounds [NUM_CFG];
        bounds = CFG_RESET;
        load_zone_bounds(bounds);
        test_random_traffic(180);
        random_zone(bounds, CFG_RED_X_LOW, 1'b1);
        random_zone(bounds, CFG_YELLOW_X_LOW, 1'b1);
        load_zone_bounds(bounds);
        test_random_traffic(180);
        // Single-point red zone at the origin inside a wide yellow zone.
        bounds = '{-1, 0, 0, 1, -1500, 1500, -1500, 1500};
        load_zone_bounds(bounds);
        test_random_traffic(150);
        bounds = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        load_zone_bounds(bounds);
        test_random_traffic(80);
        random_zone(bounds, CFG_RED_X_LOW, 1'b0);
        random_zone(bounds, CFG_YELLOW_X_LOW, 1'b0);
        load_zone_bounds(bounds);
        test_random_traffic(150);
        random_zone(bounds, CFG_RED_X_LOW, 1'b1);
        random_zone(bounds, CFG_YELLOW_X_LOW, 1'b1);
        load_zone_bounds(bounds);
        test_random_traffic(180);
    endtask

    // Receiver: short stalls mostly, now and then a long one.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_throttle && $urandom_range(0, 99) < 25) begin
            i_m_axis_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(0, 2);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_zone_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_zone_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, expected nothing, got %h",
                         $time, o_m_axis_tdata);
            end else begin
                want = pending_zone_results.pop_front();
                check_field("cluster_code", want.cluster_code, o_m_axis_tdata[1:0]);
                check_field("frame_code", want.frame_code, o_m_axis_tdata[3:2]);
                check_field("cluster_valid", want.cluster_valid, o_m_axis_tuser);
                check_field("frame_done", want.frame_done, o_m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no beat moved for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        zone_bounds = CFG_RESET;
        clear_cluster();
        frame_worst = CODE_NONE;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_zone_edges();
        test_nearest_point_rules();
        test_coordinate_extremes();
        test_random_bound_sets();
        drain_pipeline();
        $display("Sent %0d point and marker beats, checked %0d cluster results", beats_in,
                 results_seen);
        $display("over default bounds and %0d loaded zone settings.", bound_sets);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- cluster_zone_warning_top.f -----
hw/rtl/czw_pkg.sv
hw/rtl/cluster_zone_warning_top.sv
tb/testbench.sv
